// ===== sv/cdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdd_pkg
// Shared types and constants of the CDMA despreading decoder.
// ----------------------------------------------------------------------------
package cdd_pkg;

  localparam int NUM_USERS = 4;
  localparam int CHIPS     = 8;
  localparam int SAMPLE_W  = 3;
  localparam int WORD_W    = CHIPS * SAMPLE_W;
  localparam int BYTE_W    = 8;
  localparam int PART_W    = BYTE_W - 1;
  localparam int CNT_W     = 3;
  localparam int GRP_OUT_W = 3;
  localparam int SUM_W     = 8;
  localparam int LVL_W     = 5;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CHIPS-1:0]     code_t;
  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [NUM_USERS-1:0] user_bits_t;

  typedef enum logic [1:0] {
    REG_CODE_A = 2'd0,
    REG_CODE_B = 2'd1,
    REG_CODE_C = 2'd2,
    REG_CODE_D = 2'd3
  } reg_idx_t;

  localparam code_t CODE_A_RESET = 8'd27;
  localparam code_t CODE_B_RESET = 8'd46;
  localparam code_t CODE_C_RESET = 8'd92;
  localparam code_t CODE_D_RESET = 8'd66;

  localparam logic signed [SUM_W-1:0] DEC_LO = -8'sd15;
  localparam logic signed [SUM_W-1:0] DEC_HI = -8'sd8;

endpackage

// ===== sv/cdd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdd_in_if / cdd_out_if
// Valid/ready channels carrying chip words in and decoded byte groups out.
// ----------------------------------------------------------------------------
interface cdd_in_if;
  logic          valid;
  logic          ready;
  cdd_pkg::word_t chip_word;

  modport source (output valid, output chip_word, input ready);
  modport sink   (input valid, input chip_word, output ready);
endinterface

interface cdd_out_if;
  logic           valid;
  logic           ready;
  cdd_pkg::byte_t byte_user_a;
  cdd_pkg::byte_t byte_user_b;
  cdd_pkg::byte_t byte_user_c;
  cdd_pkg::byte_t byte_user_d;
  logic [cdd_pkg::GRP_OUT_W-1:0] group_index;

  modport source (output valid, output byte_user_a, output byte_user_b,
                  output byte_user_c, output byte_user_d, output group_index,
                  input ready);
  modport sink   (input valid, input byte_user_a, input byte_user_b,
                  input byte_user_c, input byte_user_d, input group_index,
                  output ready);
endinterface

// ===== sv/cdd_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdd_lane
// One user's correlator: signed sum of eight chip levels against the code,
// then the hard decision on the sum.
// ----------------------------------------------------------------------------
module cdd_lane (
  input  cdd_pkg::word_t chip_word,
  input  cdd_pkg::code_t code,
  output logic           dec_bit
);

  logic signed [cdd_pkg::LVL_W-1:0] lvl  [cdd_pkg::CHIPS];
  logic signed [cdd_pkg::LVL_W-1:0] term [cdd_pkg::CHIPS];
  logic signed [cdd_pkg::SUM_W-1:0] sum;

  always_comb begin
    sum = '0;
    for (int k = 0; k < cdd_pkg::CHIPS; k++) begin
      lvl[k]  = $signed({1'b0, chip_word[cdd_pkg::WORD_W-cdd_pkg::SAMPLE_W*(k+1) +:
                                         cdd_pkg::SAMPLE_W], 1'b0}) - 5'sd4;
      term[k] = code[cdd_pkg::CHIPS-1-k] ? lvl[k] : -lvl[k];
      sum     = sum + {{(cdd_pkg::SUM_W-cdd_pkg::LVL_W){term[k][cdd_pkg::LVL_W-1]}},
                       term[k]};
    end
  end

  assign dec_bit = !((sum >= cdd_pkg::DEC_LO) && (sum <= cdd_pkg::DEC_HI));

endmodule

// ===== sv/cdd_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdd_merge
// Gather the lane decisions into per-user bytes and register each finished
// group of four bytes with its group index.
// ----------------------------------------------------------------------------
module cdd_merge #(
  parameter int BYTES_PER_USER = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cdd_pkg::user_bits_t lane_bits,
  cdd_out_if.source           out_chan
);

  localparam int GROUP_W = (BYTES_PER_USER > 1) ? $clog2(BYTES_PER_USER) : 1;
  localparam logic [GROUP_W-1:0] GROUP_LAST = GROUP_W'(BYTES_PER_USER - 1);
  localparam logic [cdd_pkg::CNT_W-1:0] CNT_LAST = 3'd7;

  logic [cdd_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [cdd_pkg::PART_W-1:0] part_r   [cdd_pkg::NUM_USERS];
  logic [cdd_pkg::PART_W-1:0] part_nxt [cdd_pkg::NUM_USERS];
  logic [GROUP_W-1:0]         group_r, group_nxt;
  logic                       out_valid_r, out_valid_nxt;
  cdd_pkg::byte_t             byte_r   [cdd_pkg::NUM_USERS];
  cdd_pkg::byte_t             byte_nxt [cdd_pkg::NUM_USERS];
  logic [GROUP_W-1:0]         gidx_r, gidx_nxt;
  logic [GROUP_W+cdd_pkg::GRP_OUT_W-1:0] gidx_ext;
  logic                       in_fire, emit;

  assign in_ready = !out_valid_r || out_chan.ready;
  assign in_fire  = in_valid && in_ready;
  assign emit     = in_fire && (count_r == CNT_LAST);

  always_comb begin
    count_nxt     = count_r;
    group_nxt     = group_r;
    gidx_nxt      = gidx_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    for (int u = 0; u < cdd_pkg::NUM_USERS; u++) begin
      part_nxt[u] = part_r[u];
      byte_nxt[u] = byte_r[u];
    end
    if (in_fire) begin
      if (emit) begin
        count_nxt     = '0;
        gidx_nxt      = group_r;
        group_nxt     = (group_r == GROUP_LAST) ? '0 : group_r + 1'b1;
        out_valid_nxt = 1'b1;
        for (int u = 0; u < cdd_pkg::NUM_USERS; u++) begin
          byte_nxt[u] = {part_r[u], lane_bits[u]};
          part_nxt[u] = '0;
        end
      end else begin
        count_nxt = count_r + 1'b1;
        for (int u = 0; u < cdd_pkg::NUM_USERS; u++) begin
          part_nxt[u] = {part_r[u][cdd_pkg::PART_W-2:0], lane_bits[u]};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      group_r     <= '0;
      out_valid_r <= 1'b0;
      for (int u = 0; u < cdd_pkg::NUM_USERS; u++) begin
        part_r[u] <= '0;
      end
    end else begin
      count_r     <= count_nxt;
      group_r     <= group_nxt;
      out_valid_r <= out_valid_nxt;
      for (int u = 0; u < cdd_pkg::NUM_USERS; u++) begin
        part_r[u] <= part_nxt[u];
      end
    end
  end

  always_ff @(posedge clk) begin
    gidx_r <= gidx_nxt;
    for (int u = 0; u < cdd_pkg::NUM_USERS; u++) begin
      byte_r[u] <= byte_nxt[u];
    end
  end

  assign gidx_ext             = {{cdd_pkg::GRP_OUT_W{1'b0}}, gidx_r};
  assign out_chan.valid       = out_valid_r;
  assign out_chan.byte_user_a = byte_r[0];
  assign out_chan.byte_user_b = byte_r[1];
  assign out_chan.byte_user_c = byte_r[2];
  assign out_chan.byte_user_d = byte_r[3];
  assign out_chan.group_index = gidx_ext[cdd_pkg::GRP_OUT_W-1:0];

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("finished group not presented");

  a_emit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (count_r == '0) && (part_r[0] == '0) && (part_r[3] == '0))
    else $error("byte state not cleared after group");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !emit) |=> count_r == $past(count_r) + 1'b1)
    else $error("word count did not advance");

  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !in_ready)
    else $error("item taken while result stalled");

  a_group_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !emit |=> group_r == $past(group_r))
    else $error("group counter moved without a group");

endmodule

// ===== sv/cdd_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdd_regs
// APB-style register file holding the four spreading codes.
// ----------------------------------------------------------------------------
module cdd_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cdd_pkg::ADDR_W-1:0]  paddr,
  input  logic [cdd_pkg::DATA_W-1:0]  pwdata,
  output logic [cdd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output cdd_pkg::code_t              codes [cdd_pkg::NUM_USERS]
);

  cdd_pkg::code_t    code_r [cdd_pkg::NUM_USERS];
  cdd_pkg::reg_idx_t idx;
  cdd_pkg::code_t    rd_code;
  logic              wr_en;

  assign idx    = cdd_pkg::reg_idx_t'(paddr[cdd_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r[0] <= cdd_pkg::CODE_A_RESET;
      code_r[1] <= cdd_pkg::CODE_B_RESET;
      code_r[2] <= cdd_pkg::CODE_C_RESET;
      code_r[3] <= cdd_pkg::CODE_D_RESET;
    end else if (wr_en) begin
      case (idx)
        cdd_pkg::REG_CODE_A: code_r[0] <= pwdata[cdd_pkg::CHIPS-1:0];
        cdd_pkg::REG_CODE_B: code_r[1] <= pwdata[cdd_pkg::CHIPS-1:0];
        cdd_pkg::REG_CODE_C: code_r[2] <= pwdata[cdd_pkg::CHIPS-1:0];
        cdd_pkg::REG_CODE_D: code_r[3] <= pwdata[cdd_pkg::CHIPS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cdd_pkg::REG_CODE_A: rd_code = code_r[0];
      cdd_pkg::REG_CODE_B: rd_code = code_r[1];
      cdd_pkg::REG_CODE_C: rd_code = code_r[2];
      cdd_pkg::REG_CODE_D: rd_code = code_r[3];
      default:             rd_code = '0;
    endcase
  end

  assign prdata = {{(cdd_pkg::DATA_W-cdd_pkg::CHIPS){1'b0}}, rd_code};

  always_comb begin
    for (int u = 0; u < cdd_pkg::NUM_USERS; u++) begin
      codes[u] = code_r[u];
    end
  end

endmodule

// ===== sv/cdma_despread_decoder.sv =====
`timescale 1ns / 1ps
// Latency: a group is output in the cycle after its eighth chip word is taken.
// Throughput: one chip word per cycle when not stalled; the four lanes decide
//   in the accepting cycle; the single output register holds a finished group.
// Reset (rst_n low, synchronous): codes return to 27, 46, 92, 66; word count,
//   partial bytes and group index clear; no result is pending.
// ----------------------------------------------------------------------------
// cdma_despread_decoder
// Four-user, eight-chip CDMA despreader: parallel correlator lanes feed a
// merge stage that packs decisions into bytes.
// ----------------------------------------------------------------------------
module cdma_despread_decoder #(
  parameter int BYTES_PER_USER = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  cdd_in_if.sink                      in_chan,
  cdd_out_if.source                   out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [cdd_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [cdd_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [cdd_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  cdd_pkg::code_t      codes [cdd_pkg::NUM_USERS];
  cdd_pkg::user_bits_t lane_bits;

  cdd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .codes   (codes)
  );

  for (genvar u = 0; u < cdd_pkg::NUM_USERS; u++) begin : g_lane
    cdd_lane u_lane (
      .chip_word (in_chan.chip_word),
      .code      (codes[u]),
      .dec_bit   (lane_bits[u])
    );
  end

  cdd_merge #(
    .BYTES_PER_USER (BYTES_PER_USER)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .lane_bits (lane_bits),
    .out_chan  (out_chan)
  );

endmodule
